// ----- src/lks_pkg.sv -----
// Shared constants, types and helper functions of the lane keeping steering law.
package lks_pkg;

    localparam int COEF_W          = 32;
    localparam int NUM_W           = 41;
    localparam int CORDIC_STEPS    = 17;
    localparam int CORDIC_PRESHIFT = 24;
    localparam int CORDIC_W        = 58;
    localparam int ANG_W           = 19;
    localparam int ANG_FRAC        = 16;
    localparam int HALF_PI_Q       = 102944;
    localparam int SQRT_STEPS      = 32;
    localparam int DIV_STEPS       = 56;
    localparam int DIST_W          = 47;
    localparam int ACC_W           = 66;
    localparam int CMD_W           = 16;
    localparam int REF_X           = 160;
    localparam int REF_Y           = 120;
    localparam int STEER_CENTER    = 100;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNERING_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DISTANCE = 3'd5;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic b_pos;
        logic flip;
    } t_cordic_ctl;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 19'sd51472;
            1:       v = 19'sd30386;
            2:       v = 19'sd16055;
            3:       v = 19'sd8150;
            4:       v = 19'sd4091;
            5:       v = 19'sd2047;
            6:       v = 19'sd1024;
            7:       v = 19'sd512;
            8:       v = 19'sd256;
            9:       v = 19'sd128;
            10:      v = 19'sd64;
            11:      v = 19'sd32;
            12:      v = 19'sd16;
            13:      v = 19'sd8;
            14:      v = 19'sd4;
            15:      v = 19'sd2;
            16:      v = 19'sd1;
            default: v = 19'sd0;
        endcase
        return v;
    endfunction

    // truncate toward zero after dropping sh fraction bits, then clamp to int16
    function automatic logic signed [CMD_W-1:0] trunc_sat(
        input logic signed [ACC_W-1:0] v,
        input int sh
    );
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] q;
        bias = (ACC_W'(1) <<< sh) - ACC_W'(1);
        if (v < 0) begin
            q = (v + bias) >>> sh;
        end else begin
            q = v >>> sh;
        end
        if (q > ACC_W'(32767)) begin
            return 16'sh7fff;
        end else if (q < -ACC_W'(32768)) begin
            return 16'sh8000;
        end
        return q[CMD_W-1:0];
    endfunction

endpackage

// ----- src/lks_cordic.sv -----
// Pipelined CORDIC vectoring unit giving the heading error in Q.16 radians.
module lks_cordic (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [lks_pkg::COEF_W-1:0]  i_coef_a,
    input  logic signed [lks_pkg::COEF_W-1:0]  i_coef_b,
    output logic signed [lks_pkg::ANG_W-1:0]   o_heading
);
    localparam int W = lks_pkg::CORDIC_W;
    localparam int N = lks_pkg::CORDIC_STEPS;
    localparam int AW = lks_pkg::ANG_W;

    logic [lks_pkg::COEF_W-1:0] mag_a;
    logic [lks_pkg::COEF_W-1:0] mag_b;
    lks_pkg::t_cordic_ctl       ctl_in;

    logic signed [W-1:0]  x_src [N];
    logic signed [W-1:0]  y_src [N];
    logic signed [AW-1:0] z_src [N];
    logic signed [W-1:0]  r_x   [N];
    logic signed [W-1:0]  r_y   [N];
    logic signed [AW-1:0] r_z   [N];
    lks_pkg::t_cordic_ctl r_ctl [N];

    always_comb begin
        mag_a = i_coef_a[lks_pkg::COEF_W-1] ? 32'(-i_coef_a) : 32'(i_coef_a);
        mag_b = i_coef_b[lks_pkg::COEF_W-1] ? 32'(-i_coef_b) : 32'(i_coef_b);
        ctl_in.a_zero = (i_coef_a == '0);
        ctl_in.b_zero = (i_coef_b == '0);
        ctl_in.b_pos  = ~i_coef_b[lks_pkg::COEF_W-1] && (i_coef_b != '0);
        ctl_in.flip   = i_coef_a[lks_pkg::COEF_W-1] ^ i_coef_b[lks_pkg::COEF_W-1];
    end

    assign x_src[0] = $signed({2'b00, mag_a, 24'b0});
    assign y_src[0] = $signed({2'b00, mag_b, 24'b0});
    assign z_src[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_step
        if (i > 0) begin : g_link
            assign x_src[i] = r_x[i-1];
            assign y_src[i] = r_y[i-1];
            assign z_src[i] = r_z[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_src[i] >= 0) begin
                    r_x[i] <= x_src[i] + (y_src[i] >>> i);
                    r_y[i] <= y_src[i] - (x_src[i] >>> i);
                    r_z[i] <= z_src[i] + lks_pkg::atan_entry(i);
                end else begin
                    r_x[i] <= x_src[i] - (y_src[i] >>> i);
                    r_y[i] <= y_src[i] + (x_src[i] >>> i);
                    r_z[i] <= z_src[i] - lks_pkg::atan_entry(i);
                end
                r_ctl[i] <= (i == 0) ? ctl_in : r_ctl[(i == 0) ? 0 : i-1];
            end
        end
    end

    always_comb begin
        if (r_ctl[N-1].a_zero) begin
            o_heading = r_ctl[N-1].b_pos ? AW'(lks_pkg::HALF_PI_Q) : -AW'(lks_pkg::HALF_PI_Q);
        end else if (r_ctl[N-1].b_zero) begin
            o_heading = '0;
        end else if (r_ctl[N-1].flip) begin
            o_heading = -r_z[N-1];
        end else begin
            o_heading = r_z[N-1];
        end
    end

endmodule

// ----- src/lks_dist.sv -----
// Pipelined distance unit: line norm by square root, then point distance by division.
module lks_dist (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [lks_pkg::COEF_W-1:0]  i_coef_a,
    input  logic signed [lks_pkg::COEF_W-1:0]  i_coef_b,
    input  logic signed [lks_pkg::COEF_W-1:0]  i_coef_c,
    output logic        [lks_pkg::DIST_W-1:0]  o_dist
);
    localparam int NS = lks_pkg::SQRT_STEPS;
    localparam int ND = lks_pkg::DIV_STEPS;
    localparam int NW = lks_pkg::NUM_W;

    logic        [63:0]   r_aa;
    logic        [63:0]   r_bb;
    logic signed [NW-1:0] r_num;
    logic        [63:0]   r_sum;
    logic        [NW-2:0] r_n;

    logic [63:0]   sv_src [NS];
    logic [63:0]   sr_src [NS];
    logic [NW-2:0] sn_src [NS];
    logic [63:0]   r_sv   [NS];
    logic [63:0]   r_sr   [NS];
    logic [NW-2:0] r_sn   [NS];

    logic [ND-1:0] w_src   [ND];
    logic [31:0]   rem_src [ND];
    logic [31:0]   d_src   [ND];
    logic [ND-1:0] r_w     [ND];
    logic [31:0]   r_rem   [ND];
    logic [31:0]   r_d     [ND];

    logic [lks_pkg::DIST_W-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa  <= 64'(i_coef_a) * 64'(i_coef_a);
            r_bb  <= 64'(i_coef_b) * 64'(i_coef_b);
            r_num <= NW'(i_coef_a) * NW'(lks_pkg::REF_X)
                   + NW'(i_coef_b) * NW'(lks_pkg::REF_Y) + NW'(i_coef_c);
            r_sum <= r_aa + r_bb;
            r_n   <= r_num[NW-1] ? (NW-1)'(-r_num) : (NW-1)'(r_num);
        end
    end

    assign sv_src[0] = r_sum;
    assign sr_src[0] = '0;
    assign sn_src[0] = r_n;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        if (k > 0) begin : g_link
            assign sv_src[k] = r_sv[k-1];
            assign sr_src[k] = r_sr[k-1];
            assign sn_src[k] = r_sn[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (sv_src[k] >= sr_src[k] + BIT) begin
                    r_sv[k] <= sv_src[k] - (sr_src[k] + BIT);
                    r_sr[k] <= (sr_src[k] >> 1) + BIT;
                end else begin
                    r_sv[k] <= sv_src[k];
                    r_sr[k] <= sr_src[k] >> 1;
                end
                r_sn[k] <= sn_src[k];
            end
        end
    end

    assign w_src[0]   = {r_sn[NS-1], 16'b0};
    assign rem_src[0] = '0;
    assign d_src[0]   = r_sr[NS-1][31:0];

    for (genvar j = 0; j < ND; j++) begin : g_div
        logic [32:0] rem2;
        logic        ge;
        if (j > 0) begin : g_link
            assign w_src[j]   = r_w[j-1];
            assign rem_src[j] = r_rem[j-1];
            assign d_src[j]   = r_d[j-1];
        end
        assign rem2 = {rem_src[j], w_src[j][ND-1]};
        assign ge   = (rem2 >= {1'b0, d_src[j]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? 32'(rem2 - {1'b0, d_src[j]}) : rem2[31:0];
                r_w[j]   <= {w_src[j][ND-2:0], ge};
                r_d[j]   <= d_src[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_w[ND-1] > (ND'(1) << 46)) begin
                r_dist <= lks_pkg::DIST_W'(1) << 46;
            end else begin
                r_dist <= r_w[ND-1][lks_pkg::DIST_W-1:0];
            end
        end
    end

    assign o_dist = r_dist;

endmodule

// ----- src/lane_keeping_steering_law.sv -----
// Top level of the lane keeping steering law: config registers, command math, output stage.
// Throughput: one request per cycle while the skid register is empty; the whole pipeline
// stalls while it holds a result. The 17-step CORDIC, 32-step square root and
// 56-step divider are fully pipelined, one step per stage.
// A line with A and B both zero yields no result.
// Reset clears the pipeline, output and skid valid bits and loads the
// register defaults; no memory clearing pass.
module lane_keeping_steering_law #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [lks_pkg::COEF_W-1:0]   i_coef_a,
    input  logic signed [lks_pkg::COEF_W-1:0]   i_coef_b,
    input  logic signed [lks_pkg::COEF_W-1:0]   i_coef_c,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lks_pkg::CMD_W-1:0]    o_steering_cmd,
    output logic signed [lks_pkg::CMD_W-1:0]    o_speed_cmd,
    input  logic                                i_cfg_we,
    input  logic [lks_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lks_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int SH   = GAIN_FRAC_BITS + lks_pkg::ANG_FRAC;
    localparam int AW   = lks_pkg::ANG_W;
    localparam int ACW  = lks_pkg::ACC_W;
    localparam int CW   = lks_pkg::CMD_W;
    localparam int HDLY = 74;
    localparam int LAT  = 95;

    logic signed [15:0] r_dg;
    logic signed [15:0] r_hg;
    logic signed [15:0] r_bg;
    logic        [14:0] r_ts;
    logic        [14:0] r_cs;
    logic        [9:0]  r_tld;

    logic                       en;
    logic                       in_ok;
    logic                       out_fire;
    logic signed [AW-1:0]       heading;
    logic [lks_pkg::DIST_W-1:0] dist_q;
    logic signed [AW-1:0]       h_abs;
    logic signed [47:0]         dist_err;

    logic signed [AW-1:0] r_hd [HDLY];
    logic [LAT-1:0]       r_vld;

    logic signed [63:0]  r_p1;
    logic signed [34:0]  r_p2;
    logic signed [34:0]  r_bh;
    logic signed [15:0]  r_diff;
    logic signed [ACW-1:0] r_accs;
    logic signed [50:0]  r_bhd;
    logic signed [CW-1:0] r_steer3;
    logic signed [ACW-1:0] r_accv;
    logic signed [CW-1:0] r_steer4;
    logic signed [CW-1:0] r_speed4;

    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_steer;
    logic signed [CW-1:0] r_out_speed;
    logic                 r_sk_valid;
    logic signed [CW-1:0] r_sk_steer;
    logic signed [CW-1:0] r_sk_speed;

    assign en         = ~r_sk_valid;
    assign o_in_ready = en;
    assign in_ok      = i_in_valid && (i_coef_a != '0 || i_coef_b != '0);
    assign out_fire   = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dg  <= 16'sd128;
            r_hg  <= 16'sd4096;
            r_bg  <= 16'sd256;
            r_ts  <= 15'd800;
            r_cs  <= 15'd400;
            r_tld <= 10'd90;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lks_pkg::REG_DISTANCE_GAIN:   r_dg  <= $signed(i_cfg_data);
                lks_pkg::REG_HEADING_GAIN:    r_hg  <= $signed(i_cfg_data);
                lks_pkg::REG_BRAKE_GAIN:      r_bg  <= $signed(i_cfg_data);
                lks_pkg::REG_TOP_SPEED:       r_ts  <= i_cfg_data[14:0];
                lks_pkg::REG_CORNERING_SPEED: r_cs  <= i_cfg_data[14:0];
                lks_pkg::REG_TARGET_DISTANCE: r_tld <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    lks_cordic u_cordic (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_coef_a  (i_coef_a),
        .i_coef_b  (i_coef_b),
        .o_heading (heading)
    );

    lks_dist u_dist (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .o_dist   (dist_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], in_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd[0] <= heading;
            for (int k = 1; k < HDLY; k++) begin
                r_hd[k] <= r_hd[k-1];
            end
        end
    end

    assign h_abs    = r_hd[HDLY-1][AW-1] ? -r_hd[HDLY-1] : r_hd[HDLY-1];
    assign dist_err = $signed({1'b0, dist_q}) - $signed({22'b0, r_tld, 16'b0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1     <= r_dg * dist_err;
            r_p2     <= r_hg * r_hd[HDLY-1];
            r_bh     <= r_bg * h_abs;
            r_diff   <= $signed({1'b0, r_ts}) - $signed({1'b0, r_cs});
            r_accs   <= ($signed(ACW'(lks_pkg::STEER_CENTER)) <<< SH) + ACW'(r_p1) + ACW'(r_p2);
            r_bhd    <= r_bh * r_diff;
            r_steer3 <= lks_pkg::trunc_sat(r_accs, SH);
            r_accv   <= ACW'(r_bhd) - ($signed(ACW'(r_ts)) <<< SH);
            r_steer4 <= r_steer3;
            r_speed4 <= lks_pkg::trunc_sat(r_accv, SH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (out_fire) begin
                r_out_steer <= r_sk_steer;
                r_out_speed <= r_sk_speed;
                r_sk_valid  <= 1'b0;
            end
        end else if (r_vld[LAT-1]) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
                r_out_steer <= r_steer4;
                r_out_speed <= r_speed4;
            end else begin
                r_sk_valid <= 1'b1;
                r_sk_steer <= r_steer4;
                r_sk_speed <= r_speed4;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_steering_cmd = r_out_steer;
    assign o_speed_cmd    = r_out_speed;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid holds a result while the output is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_valid && !i_out_ready) |=> r_sk_valid)
        else $error("skid result dropped without output request");

    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_null_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && i_in_valid && i_coef_a == '0 && i_coef_b == '0) |=> !r_vld[0])
        else $error("degenerate line entered the pipeline");

endmodule
